>>> rtl/wpe_pkg.sv
package wpe_pkg;

  localparam int unsigned VW = 6;          // vertex field width
  localparam int unsigned CW = 7;          // vertex count register width
  localparam int unsigned QW = 17;         // Q1.16 weight width
  localparam int unsigned DIV_STEPS = QW - 1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_RANGE  = 3'd1,
    ST_SELF   = 3'd2,
    ST_DUP    = 3'd3,
    ST_ABSENT = 3'd4
  } status_e;

  typedef struct packed {
    logic          load;       // take input item, issue first reads
    logic          check;      // classify item, clear sums, latch numerators
    logic          commit;     // write new edge and degree counts
    logic          rd;         // walk read of degree memories
    logic [CW-1:0] rd_idx;
    logic          acc;        // accumulate last walk read
    logic          div_start;
    logic          div_step;
    logic          out_load;
  } cmd_t;

  typedef struct packed {
    logic          go_insert;
    logic          go_query;
    logic [CW-1:0] limit;
  } stat_t;

endpackage

>>> rtl/wpe_div.sv
module wpe_div #(
  parameter int unsigned W = 12
) (
  input  logic                  clk_i,
  input  logic                  start_i,
  input  logic                  step_i,
  input  logic [W-1:0]          num_i,
  input  logic [W-1:0]          den_i,
  output logic [wpe_pkg::QW-1:0] quo_o
);
  import wpe_pkg::*;

  // restoring division of num*2^16 by den, num <= den
  logic [W-1:0]  rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [W:0]    shifted;

  always_comb begin
    shifted = {rem_q, 1'b0};
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (start_i) begin
      if (num_i >= den_i) begin
        rem_d = num_i - den_i;
        quo_d = QW'(1);
      end else begin
        rem_d = num_i;
        quo_d = '0;
      end
    end else if (step_i) begin
      if (shifted >= {1'b0, den_i}) begin
        rem_d = W'(shifted - {1'b0, den_i});
        quo_d = {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_d = W'(shifted);
        quo_d = {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

>>> rtl/wpe_ctrl.sv
module wpe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  input  wpe_pkg::stat_t stat_i,
  output wpe_pkg::cmd_t  cmd_o
);
  import wpe_pkg::*;

  typedef enum logic [2:0] {
    IDLE, CHECK, WALK, DRAIN, DIV_INIT, DIV_RUN, FIN
  } state_e;

  state_e        state_q;
  logic [CW-1:0] vtx_q;
  logic          acc_q;
  logic [3:0]    cnt_q;
  logic          m_valid_q;

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      IDLE: begin
        s_ready_o = 1'b1;
        cmd_o.load = s_valid_i;
      end
      CHECK: begin
        cmd_o.check  = 1'b1;
        cmd_o.commit = stat_i.go_insert;
      end
      WALK: begin
        cmd_o.rd     = 1'b1;
        cmd_o.rd_idx = vtx_q;
        cmd_o.acc    = acc_q;
      end
      DRAIN:    cmd_o.acc = 1'b1;
      DIV_INIT: cmd_o.div_start = 1'b1;
      DIV_RUN:  cmd_o.div_step = 1'b1;
      FIN:      cmd_o.out_load = !m_valid_q || m_ready_i;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      vtx_q     <= '0;
      acc_q     <= 1'b0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (s_valid_i) state_q <= CHECK;
        end
        CHECK: begin
          vtx_q <= '0;
          acc_q <= 1'b0;
          state_q <= stat_i.go_query ? WALK : FIN;
        end
        WALK: begin
          acc_q <= 1'b1;
          vtx_q <= vtx_q + 1'b1;
          if (vtx_q == stat_i.limit - 1'b1) state_q <= DRAIN;
        end
        DRAIN: state_q <= DIV_INIT;
        DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= DIV_RUN;
        end
        DIV_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 4'(DIV_STEPS - 1)) state_q <= FIN;
        end
        FIN: begin
          if (cmd_o.out_load) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

>>> rtl/wpe_dp.sv
module wpe_dp #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [wpe_pkg::CW-1:0]     cfg_wr_data_i,
  input  logic                       kind_i,
  input  logic [wpe_pkg::VW-1:0]     src_i,
  input  logic [wpe_pkg::VW-1:0]     dst_i,
  input  wpe_pkg::cmd_t              cmd_i,
  output wpe_pkg::stat_t             stat_o,
  output logic [2:0]                 status_o,
  output logic [wpe_pkg::QW-1:0]     in_weight_o,
  output logic [wpe_pkg::QW-1:0]     out_weight_o
);
  import wpe_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned DW = AW;          // degree <= MAX_VERTICES-1
  localparam int unsigned SW = 2 * AW + 1;  // holds either sum

  // vertex limit
  logic [CW-1:0] limit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= (MAX_VERTICES < 64) ? CW'(MAX_VERTICES) : CW'(64);
    end else if (cfg_wr_en_i) begin
      limit_q <= (32'(cfg_wr_data_i) > MAX_VERTICES) ? CW'(MAX_VERTICES) : cfg_wr_data_i;
    end
  end

  // item registers
  logic          kind_q, bad_q;
  logic [AW-1:0] src_q, dst_q;
  logic [AW-1:0] src_a, dst_a, out_a;
  assign src_a = AW'(32'(src_i));
  assign dst_a = AW'(32'(dst_i));
  assign out_a = (kind_i == KIND_QUERY) ? dst_a : src_a;

  // memories, valid bits cleared at reset
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [DW-1:0]           ind_mem [MAX_VERTICES];
  logic [DW-1:0]           outd_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q, ind_vld_q, outd_vld_q;
  logic [MAX_VERTICES-1:0] row_rd_q;
  logic [DW-1:0]           ind_rd_q, outd_rd_q;
  logic                    row_rv_q, ind_rv_q, outd_rv_q;
  logic [AW-1:0]           walk_a, walk_idx_q;

  assign walk_a = AW'(32'(cmd_i.rd_idx));

  logic [MAX_VERTICES-1:0] row_eff;
  logic [DW-1:0]           ind_val, outd_val;
  assign row_eff  = row_rv_q ? row_rd_q : '0;
  assign ind_val  = ind_rv_q ? ind_rd_q : '0;
  assign outd_val = outd_rv_q ? outd_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_rd_q <= adj_mem[src_a];
    end
    if (cmd_i.load) begin
      ind_rd_q  <= ind_mem[dst_a];
      outd_rd_q <= outd_mem[out_a];
    end else if (cmd_i.rd) begin
      ind_rd_q  <= ind_mem[walk_a];
      outd_rd_q <= outd_mem[walk_a];
    end
    if (cmd_i.commit) begin
      adj_mem[src_q]  <= row_eff | (MAX_VERTICES'(1) << dst_q);
      ind_mem[dst_q]  <= ind_val + 1'b1;
      outd_mem[src_q] <= outd_val + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q  <= '0;
      ind_vld_q  <= '0;
      outd_vld_q <= '0;
      row_rv_q   <= 1'b0;
      ind_rv_q   <= 1'b0;
      outd_rv_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        row_rv_q  <= row_vld_q[src_a];
        ind_rv_q  <= ind_vld_q[dst_a];
        outd_rv_q <= outd_vld_q[out_a];
      end else if (cmd_i.rd) begin
        ind_rv_q  <= ind_vld_q[walk_a];
        outd_rv_q <= outd_vld_q[walk_a];
      end
      if (cmd_i.commit) begin
        row_vld_q[src_q]  <= 1'b1;
        ind_vld_q[dst_q]  <= 1'b1;
        outd_vld_q[src_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      src_q  <= src_a;
      dst_q  <= dst_a;
      bad_q  <= ({1'b0, src_i} >= limit_q) || ({1'b0, dst_i} >= limit_q);
    end
    if (cmd_i.rd) walk_idx_q <= walk_a;
  end

  // classification
  logic    edge_set;
  status_e code;
  assign edge_set = row_eff[dst_q];

  always_comb begin
    if (bad_q) begin
      code = ST_RANGE;
    end else if (kind_q == KIND_INSERT) begin
      if (src_q == dst_q) code = ST_SELF;
      else if (edge_set)  code = ST_DUP;
      else                code = ST_OK;
    end else begin
      code = edge_set ? ST_OK : ST_ABSENT;
    end
  end

  assign stat_o.go_insert = (code == ST_OK) && (kind_q == KIND_INSERT);
  assign stat_o.go_query  = (code == ST_OK) && (kind_q == KIND_QUERY);
  assign stat_o.limit     = limit_q;

  // sums and numerators
  logic [SW-1:0] sum_in_q, sum_out_q, num_in_q, num_out_q;
  logic          ok_query_q;
  status_e       code_q;
  logic [DW:0]   od2;
  assign od2 = (outd_val == '0) ? (DW+1)'(1) : {outd_val, 1'b0};

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      sum_in_q   <= '0;
      sum_out_q  <= '0;
      num_in_q   <= SW'(ind_val);
      num_out_q  <= SW'(od2);
      code_q     <= code;
      ok_query_q <= stat_o.go_query;
    end else if (cmd_i.acc && row_eff[walk_idx_q]) begin
      sum_in_q  <= sum_in_q + SW'(ind_val);
      sum_out_q <= sum_out_q + SW'(od2);
    end
  end

  logic [QW-1:0] q_in, q_out;

  wpe_div #(.W(SW)) u_div_in (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_in_q),
    .den_i   (sum_in_q),
    .quo_o   (q_in)
  );

  wpe_div #(.W(SW)) u_div_out (
    .clk_i   (clk_i),
    .start_i (cmd_i.div_start),
    .step_i  (cmd_i.div_step),
    .num_i   (num_out_q),
    .den_i   (sum_out_q),
    .quo_o   (q_out)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_o     <= code_q;
      in_weight_o  <= ok_query_q ? q_in : '0;
      out_weight_o <= ok_query_q ? q_out : '0;
    end
  end

endmodule

>>> rtl/weighted_pagerank_edge_weights.sv
// Channel   | Dir | Signals                     | Payload
// s_axis    | in  | tvalid tready tdata tuser   | tdata: src, dst; tuser: kind
// m_axis    | out | tvalid tready tdata tuser   | tdata: in_weight, out_weight; tuser: status
// cfg       | in  | cfg_wr_en_i cfg_wr_data_i   | num_vertices
//
// One item at a time. Insert or rejected item: accept, CHECK, then FIN loads the result.
// Query: CHECK, the adjacency row walk (one vertex a cycle through the degree memory
// read ports, over limit vertices), DRAIN, the 17-step dividers and FIN.
// The result waits in an output register; the next item is taken meanwhile.
// Reset clears the graph at once through per-row and per-vertex valid bits.
module weighted_pagerank_edge_weights #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [6:0]  cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] src, [11:6] dst, [15:12] zero
  input  logic        s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [16:0] in_weight, [33:17] out_weight, [39:34] zero
  output logic [2:0]  m_axis_tuser    // [2:0] status
);
  import wpe_pkg::*;

  cmd_t          cmd;
  stat_t         stat;
  logic [QW-1:0] in_w, out_w;

  wpe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  wpe_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .kind_i        (s_axis_tuser),
    .src_i         (s_axis_tdata[5:0]),
    .dst_i         (s_axis_tdata[11:6]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (m_axis_tuser),
    .in_weight_o   (in_w),
    .out_weight_o  (out_w)
  );

  assign m_axis_tdata = {6'd0, out_w, in_w};

endmodule

>>> rtl/wpe_checker.sv
module wpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // a failed item carries no weights
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != 3'd0 |-> m_axis_tdata == 40'd0)
    else $error("weights on failed item");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= 3'd4)
    else $error("bad status code");

  a_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536 && m_axis_tdata[33:17] <= 17'd65536)
    else $error("weight above one");

  // one item in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted item back to back");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

endmodule

bind weighted_pagerank_edge_weights wpe_checker u_wpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
